// File: rtl/otsa_pkg.sv
// Shared types and constants for the owner-tagged slot allocator.
package otsa_pkg;

    localparam int SLOTS     = 8;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int OWNER_W   = 22;
    localparam int REQ_SLOT_W = 8;
    localparam int COUNT_W   = 4;

    localparam logic [1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;

    typedef enum logic [2:0] {
        ST_GRANTED         = 3'd0,
        ST_NO_TICKETS      = 3'd1,
        ST_RELEASED        = 3'd2,
        ST_INVALID_TICKET  = 3'd3,
        ST_INVALID_REQUEST = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [OWNER_W-1:0]    owner_id;
        logic [REQ_SLOT_W-1:0] slot;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [2:0]         granted_slot;
        logic [OWNER_W-1:0] granted_owner;
        logic [COUNT_W-1:0] tickets_out;
    } t_out_item;

endpackage

// File: rtl/otsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module otsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/owner_tagged_slot_allocator_unit.sv
// Owner-tagged slot allocator: top level with owner RAM, valid bits and held count.
// Flow: an accepted request is registered and its owner RAM entry is read; in S_EXEC
// the compare/commit step registers the result once the output is free. No new request
// is taken until the current one commits. A new request is taken while a result waits.
// Reset: synchronous active-low; clears valid bits, held count and handshake state.
// The owner RAM is not cleared; entries are only read behind a set valid bit.
module owner_tagged_slot_allocator_unit
    import otsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                r_state, n_state;
    t_in_item              r_req;
    logic [SLOTS-1:0]      r_valid, n_valid;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic                  in_xfer;
    logic                  commit;
    logic [OWNER_W-1:0]    ram_rdata;
    logic                  ram_we;
    logic [SLOT_W-1:0]     free_idx;
    logic                  free_found;
    logic [SLOT_W-1:0]     req_idx;
    logic                  req_in_range;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign commit     = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    assign req_idx      = r_req.slot[SLOT_W-1:0];
    assign req_in_range = (r_req.slot < REQ_SLOT_W'(SLOTS));

    // lowest free slot
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx   = SLOT_W'(i);
                free_found = 1'b1;
            end
        end
    end

    otsa_ram #(
        .WIDTH (OWNER_W),
        .DEPTH (SLOTS)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (free_idx),
        .i_wdata (r_req.owner_id),
        .i_re    (in_xfer),
        .i_raddr (i_in_item.slot[SLOT_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    case (r_req.cmd)
                        CMD_ACQUIRE: begin
                            if (r_count < COUNT_W'(SLOTS) && free_found) begin
                                ram_we                 = 1'b1;
                                n_valid[free_idx]      = 1'b1;
                                n_count                = r_count + 1'b1;
                                n_out.status           = ST_GRANTED;
                                n_out.granted_slot     = 3'(free_idx);
                                n_out.granted_owner    = r_req.owner_id;
                            end else begin
                                n_out.status = ST_NO_TICKETS;
                            end
                        end
                        CMD_RELEASE: begin
                            if (req_in_range && r_valid[req_idx] &&
                                ram_rdata == r_req.owner_id) begin
                                n_valid[req_idx] = 1'b0;
                                if (r_count != '0) begin
                                    n_count = r_count - 1'b1;
                                end
                                n_out.status = ST_RELEASED;
                            end else begin
                                n_out.status = ST_INVALID_TICKET;
                            end
                        end
                        default: begin
                            n_out.status = ST_INVALID_REQUEST;
                        end
                    endcase
                    n_out.tickets_out = n_count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req <= i_in_item;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // held count always tracks the number of valid bits
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == COUNT_W'($countones(r_valid)))
        else $error("held count differs from valid bit count");

    // a pending grant refers to a slot that is still held
    a_grant_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_GRANTED) |->
            r_valid[r_out.granted_slot[SLOT_W-1:0]])
        else $error("granted slot not marked valid");

    // a transfer in always leads to the execute cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    // reported count matches state right after a commit
    a_count_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_out_valid && r_out.tickets_out == r_count))
        else $error("reported ticket count mismatch");
`endif

endmodule
